[rtl/bspe_pkg.sv]
// Shared constants, codes and types of the B-spline point evaluator.
`default_nettype none
package bspe_pkg;

  localparam int MAX_KNOTS   = 64;
  localparam int MAX_ORDER   = 8;
  localparam int VALUE_WIDTH = 32;

  localparam int ADDR_W  = 6;   // knot and coefficient table index
  localparam int TX_W    = 33;  // knot offset t - x
  localparam int PROD_W  = 65;  // offset times coefficient
  localparam int NUM_W   = 66;  // numerator magnitude
  localparam int DEN_W   = 34;  // denominator magnitude
  localparam int TX_N    = 2 * (MAX_ORDER - 1);

  localparam logic [1:0] OP_KNOT = 2'd0;
  localparam logic [1:0] OP_COEF = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_KNOTS = 1'b1;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [NUM_W-1:0]   num_mag;
    logic [DEN_W-1:0]   den_mag;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] value;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/bspe_tables.sv]
// Knot and coefficient memories with one write port and registered reads.
`default_nettype none
module bspe_tables
  import bspe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   knot_we,
  input  wire logic                   coef_we,
  input  wire logic [ADDR_W-1:0]      waddr,
  input  wire logic [VALUE_WIDTH-1:0] wdata,
  input  wire logic [ADDR_W-1:0]      knot_raddr,
  input  wire logic [ADDR_W-1:0]      coef_raddr,
  output logic [VALUE_WIDTH-1:0]      knot_q,
  output logic [VALUE_WIDTH-1:0]      coef_q
);

  logic [VALUE_WIDTH-1:0] knot_mem [MAX_KNOTS];
  logic [VALUE_WIDTH-1:0] coef_mem [MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (knot_we) begin
      knot_mem[waddr] <= wdata;
    end
    knot_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[waddr] <= wdata;
    end
    coef_q <= coef_mem[coef_raddr];
  end

endmodule
`default_nettype wire

[rtl/bspe_div.sv]
// Radix-2 restoring divider with signed saturation of the quotient.
`default_nettype none
module bspe_div
  import bspe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                   busy;
  logic [4:0]             cnt;
  logic [DEN_W-1:0]       rem;
  logic [DEN_W-1:0]       den;
  logic [31:0]            nlo;
  logic [31:0]            quo;
  logic                   ovf;
  logic                   neg;
  logic                   done;
  logic [DEN_W:0]         trial;
  logic [VALUE_WIDTH-1:0] sat;

  assign trial = {rem, nlo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // A quotient of 2^32 or more saturates whatever its low bits are.
      ovf <= req.num_mag >= {req.den_mag, 32'd0};
      rem <= req.num_mag[NUM_W-1:32];
      nlo <= req.num_mag[31:0];
      den <= req.den_mag;
      neg <= req.neg;
      quo <= '0;
    end else if (busy) begin
      nlo <= {nlo[30:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= DEN_W'(trial - {1'b0, den});
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg) begin
      sat = (ovf || quo[31]) ? 32'h7FFF_FFFF : quo;
    end else if (ovf || quo > 32'h8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'(~quo + 32'd1);
    end
  end

  assign rsp.done  = done;
  assign rsp.value = sat;

endmodule
`default_nettype wire

[rtl/bspline_point_evaluator_core.sv]
// Top level: request handling, knot search and de Boor cell sequencer.
// An evaluate request runs the linear knot search, loads offsets and coefficients, and
// then works through the k(k-1)/2 cells, each through the one shared serial divider.
// One request is in work at a time; a result waits in the output register.
// Synchronous reset restores order 4 and knot count 1; the tables are not cleared.
`default_nettype none
module bspline_point_evaluator_core
  import bspe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // entry_index, entry_value, sample_point, zero fill
  input  wire logic [1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // spline_value
  output logic [1:0]       m_tuser,   // eval_status
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SRCH  = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_LOAD  = 11'b000_0000_1000,
    S_MUL1  = 11'b000_0001_0000,
    S_MUL2  = 11'b000_0010_0000,
    S_PREP  = 11'b000_0100_0000,
    S_DIV   = 11'b000_1000_0000,
    S_WB    = 11'b001_0000_0000,
    S_APEX  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [3:0] spline_order;
  logic [6:0] knot_count;

  logic                     accept;
  logic [ADDR_W-1:0]        in_index;
  logic [VALUE_WIDTH-1:0]   in_value;
  logic signed [31:0]       in_point;

  logic signed [31:0]       x_reg;
  logic signed [31:0]       prev;
  logic [6:0]               cnt;
  logic [ADDR_W-1:0]        idx;
  logic [ADDR_W-1:0]        base_t;
  logic [ADDR_W-1:0]        base_b;
  logic [3:0]               j;
  logic [2:0]               r;
  logic [2:0]               i;
  logic signed [TX_W-1:0]   tx [TX_N];
  logic signed [31:0]       b  [MAX_ORDER];
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [TX_W-1:0]   hi;
  logic signed [TX_W-1:0]   lo;
  logic [31:0]              res_val;
  logic [1:0]               res_st;

  logic [6:0]               n_eff;
  logic [4:0]               nt;
  logic [4:0]               load_len;
  logic [3:0]               jj;
  logic [3:0]               hi_idx;
  logic [3:0]               lo_idx;
  logic [2:0]               last_i;
  logic signed [TX_W-1:0]   mul_a;
  logic signed [31:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  num;
  logic signed [TX_W+1:0]   den;
  logic [NUM_W-1:0]         num_mag;
  logic [TX_W+1:0]          den_abs;
  logic signed [31:0]       knot_s;
  logic                     hit;
  logic                     chk_bad;
  logic                     fin_load;

  logic [ADDR_W-1:0]        knot_raddr;
  logic [ADDR_W-1:0]        coef_raddr;
  logic [VALUE_WIDTH-1:0]   knot_q;
  logic [VALUE_WIDTH-1:0]   coef_q;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_index = s_tdata[5:0];
  assign in_value = s_tdata[37:6];
  assign in_point = s_tdata[69:38];

  assign n_eff    = (knot_count > 7'(MAX_KNOTS)) ? 7'(MAX_KNOTS) : knot_count;
  assign nt       = {spline_order - 4'd1, 1'b0};
  assign load_len = (nt > {1'b0, spline_order}) ? nt : {1'b0, spline_order};
  assign jj       = j - 4'd1;
  assign hi_idx   = {1'b0, i} + spline_order - 4'd1;
  assign lo_idx   = {1'b0, i} + {1'b0, r};
  assign last_i   = 3'(spline_order - 4'd2 - {1'b0, r});
  assign knot_s   = knot_q;
  assign hit      = (cnt >= 7'd2) && (prev <= x_reg) && (x_reg < knot_s);
  assign chk_bad  = (spline_order == 4'd0) || (spline_order > 4'(MAX_ORDER)) ||
                    ({2'b0, idx} + 8'd1 < {4'b0, spline_order}) ||
                    ({2'b0, idx} + {4'b0, spline_order} > {1'b0, n_eff});
  assign fin_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // The single multiplier takes the high offset first, then the low one.
  assign mul_a = (state == S_MUL1) ? tx[hi_idx] : tx[lo_idx];
  assign mul_b = (state == S_MUL1) ? b[i] : b[3'(i + 3'd1)];
  assign prod  = mul_a * mul_b;

  assign num     = p1 - p2;
  assign den     = hi - lo;
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs = den[TX_W+1] ? (TX_W+2)'(-den) : (TX_W+2)'(den);

  assign div_req.start   = (state == S_PREP) && (den != '0);
  assign div_req.neg     = num[NUM_W-1] ^ den[TX_W+1];
  assign div_req.num_mag = num_mag;
  assign div_req.den_mag = den_abs[DEN_W-1:0];

  assign knot_raddr = (state == S_SRCH) ? cnt[ADDR_W-1:0] : ADDR_W'(base_t + {2'b0, j});
  assign coef_raddr = ADDR_W'(base_b + {2'b0, j});

  bspe_tables u_tables (
    .clk        (clk),
    .knot_we    (accept && s_tuser == OP_KNOT),
    .coef_we    (accept && s_tuser == OP_COEF),
    .waddr      (in_index),
    .wdata      (in_value),
    .knot_raddr (knot_raddr),
    .coef_raddr (coef_raddr),
    .knot_q     (knot_q),
    .coef_q     (coef_q)
  );

  bspe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order <= 4'd4;
      knot_count   <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER: spline_order <= cfg_data[3:0];
        CFG_KNOTS: knot_count   <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == OP_EVAL) begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (n_eff >= 7'd2 && hit) begin
            state <= S_CHECK;
          end else if (n_eff < 7'd2 || cnt == n_eff) begin
            state <= S_FIN;
          end
        end
        S_CHECK: state <= chk_bad ? S_FIN : S_LOAD;
        S_LOAD: begin
          if ({1'b0, j} == load_len) begin
            state <= (spline_order == 4'd1) ? S_APEX : S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_PREP;
        S_PREP: state <= (den == '0) ? S_FIN : S_DIV;
        S_DIV:  state <= div_rsp.done ? S_WB : S_DIV;
        S_WB: begin
          if (i == last_i && {1'b0, r} == spline_order - 4'd2) begin
            state <= S_APEX;
          end else begin
            state <= S_MUL1;
          end
        end
        S_APEX: state <= S_FIN;
        S_FIN:  state <= fin_load ? S_IDLE : S_FIN;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= res_val;
      m_tuser <= res_st;
    end
    unique case (state)
      S_IDLE: begin
        x_reg <= in_point;
        cnt   <= '0;
      end
      S_SRCH: begin
        cnt  <= cnt + 7'd1;
        prev <= knot_s;
        idx  <= ADDR_W'(cnt - 7'd2);
        if (!(n_eff >= 7'd2 && hit)) begin
          res_val <= '0;
          res_st  <= ST_RANGE;
        end
      end
      S_CHECK: begin
        base_t  <= ADDR_W'(idx + 6'd2 - {2'b0, spline_order});
        base_b  <= ADDR_W'(idx + 6'd1 - {2'b0, spline_order});
        j       <= '0;
        res_val <= '0;
        res_st  <= ST_ERROR;
      end
      S_LOAD: begin
        j <= j + 4'd1;
        r <= '0;
        i <= '0;
        if (j != 4'd0) begin
          if ({1'b0, jj} < nt) begin
            tx[jj] <= TX_W'(signed'(knot_s)) - TX_W'(x_reg);
          end
          if (jj < spline_order) begin
            b[jj[2:0]] <= coef_q;
          end
        end
      end
      S_MUL1: begin
        p1 <= prod;
        hi <= mul_a;
      end
      S_MUL2: begin
        p2 <= prod;
        lo <= mul_a;
      end
      S_PREP: begin
        res_val <= '0;
        res_st  <= ST_ERROR;
      end
      S_DIV: ;
      S_WB: begin
        b[i] <= div_rsp.value;
        if (i == last_i) begin
          i <= '0;
          r <= r + 3'd1;
        end else begin
          i <= i + 3'd1;
        end
      end
      S_APEX: begin
        res_val <= b[0];
        res_st  <= ST_OK;
      end
      S_FIN: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/bspe_checker.sv]
// Port-level checker of the evaluator and its bind to the top level.
`default_nettype none
module bspe_checker
  import bspe_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 32'd0)
    else $error("error result carries a nonzero value");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined status code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_EVAL |=> !s_tready)
    else $error("request taken while an evaluation runs");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the output");

endmodule

bind bspline_point_evaluator_core bspe_checker u_bspe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
